### sv/spd_pkg.sv
// Shared types, constants and helper functions of the shortest path block.
`default_nettype none

package spd_pkg;

    // Sizing of the stored graph and of the distance datapath.
    localparam int NODE_COUNT      = 16;
    localparam int WEIGHT_BITS     = 16;
    localparam int DISTANCE_BITS   = 20;
    localparam int NODE_FIELD_BITS = 4;
    localparam int LINK_FIELD_BITS = 16;
    localparam int NODE_BITS       = $clog2(NODE_COUNT);
    localparam int CNT_BITS        = $clog2(NODE_COUNT + 1);
    localparam int ADDR_BITS       = 2 * NODE_BITS;
    localparam int MEM_DEPTH       = NODE_COUNT * NODE_COUNT;
    localparam int SUM_BITS        =
        ((DISTANCE_BITS > WEIGHT_BITS) ? DISTANCE_BITS : WEIGHT_BITS) + 1;

    // Saturated distance, which also means unreachable.
    localparam logic [DISTANCE_BITS-1:0] DIST_MAX = '1;

    // Item kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_RUN   = 1'b1;

    // Input item: a link weight write or the start of a run.
    typedef struct packed {
        logic                       kind;
        logic [NODE_FIELD_BITS-1:0] row_node;
        logic [NODE_FIELD_BITS-1:0] col_node;
        logic [LINK_FIELD_BITS-1:0] link_weight;
        logic [NODE_FIELD_BITS-1:0] source_node;
    } t_in_item;

    // Result item: the outcome of a run for one node.
    typedef struct packed {
        logic [NODE_FIELD_BITS-1:0] node_index;
        logic [DISTANCE_BITS-1:0]   path_distance;
        logic [NODE_FIELD_BITS-1:0] predecessor;
        logic                       reachable;
        logic                       last;
    } t_out_item;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SELECT,
        ST_RELAX,
        ST_EMIT
    } t_state;

    // Distance plus weight, saturated at the maximum distance.
    function automatic logic [DISTANCE_BITS-1:0] sat_add(
        input logic [DISTANCE_BITS-1:0] base,
        input logic [WEIGHT_BITS-1:0]   weight
    );
        logic [SUM_BITS-1:0] sum;
        sum = SUM_BITS'(base) + SUM_BITS'(weight);
        if (sum >= SUM_BITS'(DIST_MAX)) begin
            return DIST_MAX;
        end
        return DISTANCE_BITS'(sum);
    endfunction

endpackage

`default_nettype wire

### sv/shortest_path_dijkstra.sv
// Top level of the adjacency-matrix shortest path block.
//
// A write item stores one link weight (zero means no link) in a 256-entry
// weight memory, and the block stays ready. A run item starts a Dijkstra
// search from its source node: an init sweep loads the source row, then each
// further reached node costs a minimum scan plus a relax sweep over its row,
// one memory read and one saturating add and compare per cycle, a final scan
// finds that no node is left, and the 16 result items leave in node order,
// the last one flagged; output stalls hold them back. Input ready stays low
// until the final result sits in the output register. Valid bits cleared by
// reset make the weight memory read as all zero, so no clearing pass follows
// reset. Sources and link ends outside the node range are ignored.
`default_nettype none

module shortest_path_dijkstra (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  spd_pkg::t_in_item i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output spd_pkg::t_out_item o_out
);
    import spd_pkg::*;

    // Sequencer registers.
    t_state                   r_state, n_state;
    logic [CNT_BITS-1:0]      r_cnt, n_cnt;
    logic [NODE_BITS-1:0]     r_src, n_src;
    logic [NODE_BITS-1:0]     r_pick, n_pick;
    logic [DISTANCE_BITS-1:0] r_best, n_best;
    logic                     r_found, n_found;
    logic                     r_rd_go, n_rd_go;
    logic [NODE_BITS-1:0]     r_rd_node;
    logic                     r_out_valid, n_out_valid;
    t_out_item                r_out;

    // Weight memory with one valid bit per entry.
    logic [WEIGHT_BITS-1:0]   r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]     r_mem_vld;
    logic [WEIGHT_BITS-1:0]   r_rd_weight;
    logic                     r_rd_valid;

    // Per-node run state.
    logic [DISTANCE_BITS-1:0] r_dist [NODE_COUNT];
    logic [NODE_BITS-1:0]     r_pred [NODE_COUNT];
    logic [NODE_COUNT-1:0]    r_visited;

    // Decoded control.
    logic                     in_accept;
    logic                     wr_en;
    logic [ADDR_BITS-1:0]     wr_addr;
    logic [ADDR_BITS-1:0]     rd_addr;
    logic [NODE_BITS-1:0]     cnt_node;
    logic                     cnt_end;
    logic                     cnt_last;
    logic                     sel_hit;
    logic                     mark_visit;
    logic                     out_load;
    logic [WEIGHT_BITS-1:0]   rd_weight;
    logic [DISTANCE_BITS-1:0] cand;
    logic                     relax_hit;
    logic [DISTANCE_BITS-1:0] init_dist;
    logic                     src_ok;

    assign in_accept = i_in_valid && o_in_ready;
    assign cnt_node  = r_cnt[NODE_BITS-1:0];
    assign cnt_end   = (r_cnt == CNT_BITS'(NODE_COUNT));
    assign cnt_last  = (r_cnt == CNT_BITS'(NODE_COUNT - 1));
    assign src_ok    = (int'(i_in.source_node) < NODE_COUNT);

    // A link write lands only when both ends name existing nodes.
    assign wr_en   = in_accept && (i_in.kind == KIND_WRITE)
                     && (int'(i_in.row_node) < NODE_COUNT)
                     && (int'(i_in.col_node) < NODE_COUNT);
    assign wr_addr = {NODE_BITS'(i_in.row_node), NODE_BITS'(i_in.col_node)};

    // The init sweep reads the source row, the relax sweep the picked row.
    assign rd_addr = (r_state == ST_INIT) ? {r_src, cnt_node} : {r_pick, cnt_node};

    // An entry that was never written reads as no link.
    assign rd_weight = r_rd_valid ? r_rd_weight : '0;

    // Saturating add and compare for one neighbor in the relax sweep.
    assign cand      = sat_add(r_best, rd_weight);
    assign relax_hit = !r_visited[r_rd_node] && (rd_weight != '0)
                       && (cand < r_dist[r_rd_node]);
    assign init_dist = (r_rd_node == r_src) ? '0 :
                       (rd_weight == '0) ? DIST_MAX : sat_add('0, rd_weight);

    // Minimum scan compare for the node under the counter.
    assign sel_hit = !r_visited[cnt_node] && (r_dist[cnt_node] < r_best);

    // Next state and control of the sequencer.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_src       = r_src;
        n_pick      = r_pick;
        n_best      = r_best;
        n_found     = r_found;
        n_rd_go     = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        mark_visit  = 1'b0;
        out_load    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // Ready is high here, so valid alone marks an accepted item.
                o_in_ready = 1'b1;
                if (i_in_valid && (i_in.kind == KIND_RUN) && src_ok) begin
                    n_src   = NODE_BITS'(i_in.source_node);
                    n_cnt   = '0;
                    n_state = ST_INIT;
                end
            end
            ST_INIT, ST_RELAX: begin
                if (cnt_end) begin
                    n_cnt   = '0;
                    n_best  = DIST_MAX;
                    n_found = 1'b0;
                    n_state = ST_SELECT;
                end else begin
                    n_rd_go = 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                end
            end
            ST_SELECT: begin
                if (sel_hit) begin
                    n_best  = r_dist[cnt_node];
                    n_pick  = cnt_node;
                    n_found = 1'b1;
                end
                if (cnt_last) begin
                    n_cnt = '0;
                    if (n_found) begin
                        mark_visit = 1'b1;
                        n_state    = ST_RELAX;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    if (cnt_last) begin
                        n_cnt   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_found     <= 1'b0;
            r_rd_go     <= 1'b0;
            r_out_valid <= 1'b0;
            r_mem_vld   <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_found     <= n_found;
            r_rd_go     <= n_rd_go;
            r_out_valid <= n_out_valid;
            if (wr_en) begin
                r_mem_vld[wr_addr] <= 1'b1;
            end
        end
    end

    // Weight memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_in.link_weight[WEIGHT_BITS-1:0];
        end
        r_rd_weight <= r_mem[rd_addr];
        r_rd_valid  <= r_mem_vld[rd_addr];
    end

    // Run datapath: the registered read of each sweep updates one node.
    always_ff @(posedge i_clk) begin
        r_src     <= n_src;
        r_pick    <= n_pick;
        r_best    <= n_best;
        r_rd_node <= cnt_node;
        if (r_rd_go && (r_state == ST_INIT)) begin
            r_dist[r_rd_node]    <= init_dist;
            r_pred[r_rd_node]    <= r_src;
            r_visited[r_rd_node] <= (r_rd_node == r_src);
        end
        if (r_rd_go && (r_state == ST_RELAX) && relax_hit) begin
            r_dist[r_rd_node] <= cand;
            r_pred[r_rd_node] <= r_pick;
        end
        if (mark_visit) begin
            r_visited[n_pick] <= 1'b1;
        end
    end

    // Output register: one result item per node.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.node_index    <= NODE_FIELD_BITS'(cnt_node);
            r_out.path_distance <= r_dist[cnt_node];
            r_out.predecessor   <= NODE_FIELD_BITS'(r_pred[cnt_node]);
            r_out.reachable     <= (r_dist[cnt_node] < DIST_MAX);
            r_out.last          <= cnt_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

### sv/spd_checker.sv
// Port-level checker for the shortest path block and its bind statement.
`default_nettype none

module spd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input spd_pkg::t_in_item  i_in,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input spd_pkg::t_out_item o_out
);
    import spd_pkg::*;

    // A stalled result item holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result item changed while stalled");

    // A run item with a source in range blocks further input items.
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in.kind == KIND_RUN)
        && (int'(i_in.source_node) < NODE_COUNT) |=> !o_in_ready)
        else $error("block stayed ready after a run item");

    // A link write item leaves the block ready.
    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in.kind == KIND_WRITE) |=> o_in_ready)
        else $error("block went busy after a write item");

    // Results of a run follow each other in node order without gaps.
    a_node_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out.last |=> o_out_valid
        && (o_out.node_index == NODE_FIELD_BITS'($past(o_out.node_index) + 1'b1)))
        else $error("result items out of node order");

    // The last flag marks the final node.
    a_last_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.last |->
        (o_out.node_index == NODE_FIELD_BITS'(NODE_COUNT - 1)))
        else $error("last flag on a node other than the final one");

endmodule

bind shortest_path_dijkstra spd_checker u_spd_checker (.*);

`default_nettype wire
